// ===== rtl/mtct_pkg.sv =====
// mtct_pkg: constants, codes and helper functions of the meter telegram checker
// used by the tokenizer top level and the bench; no dependencies
`timescale 1ns / 1ps
package mtct_pkg;

  localparam int unsigned BODY_DEPTH = 2048;
  localparam int unsigned OBIS_MAX   = 16;
  localparam int unsigned VALUES_MAX = 12;
  localparam int unsigned VALUE_MAX  = 32;
  localparam int unsigned LINE_CAP   = OBIS_MAX + VALUES_MAX * (VALUE_MAX + 2) + 8;
  localparam int unsigned CRC_DIGITS = 4;

  localparam int unsigned AW    = $clog2(BODY_DEPTH);
  localparam int unsigned POS_W = $clog2(BODY_DEPTH + 1);
  localparam int unsigned CAP_W = $clog2(LINE_CAP);
  localparam int unsigned VL_W  = $clog2(VALUE_MAX);
  localparam int unsigned VI_W  = $clog2(VALUES_MAX + 1);

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_NO_START = 3'd1;
  localparam logic [2:0] STS_NO_END   = 3'd2;
  localparam logic [2:0] STS_TRUNC    = 3'd3;
  localparam logic [2:0] STS_CRC      = 3'd4;
  localparam logic [2:0] STS_OVF      = 3'd5;

  localparam logic [2:0] TK_OBIS    = 3'd0;
  localparam logic [2:0] TK_VALUE   = 3'd1;
  localparam logic [2:0] TK_VAL_END = 3'd2;
  localparam logic [2:0] TK_F_END   = 3'd3;
  localparam logic [2:0] TK_NONE    = 3'd4;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef enum logic [5:0] {
    PH_SEEK   = 6'b000001,
    PH_HEAD   = 6'b000010,
    PH_BODY   = 6'b000100,
    PH_DIGITS = 6'b001000,
    PH_TAIL   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  typedef enum logic [3:0] {
    SC_IDLE  = 4'b0001,
    SC_OBIS  = 4'b0010,
    SC_VALUE = 4'b0100,
    SC_FEND  = 4'b1000
  } scan_e;

  typedef struct packed {
    logic       is_status;
    logic [2:0] status_code;
    logic [2:0] token_kind;
    logic [7:0] token_char;
    logic [3:0] value_slot;
  } result_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // bit 4 flags a non-hex character, low nibble then reads as all ones
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    r = 5'h1F;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF) || (c == CH_SP) || (c == CH_TAB);
  endfunction

endpackage

// ===== rtl/mtct_req_if.sv =====
// mtct_req_if: request channel carrying push and pull operations
// plain valid/ready handshake; no dependencies
`timescale 1ns / 1ps
interface mtct_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output opcode, output data_byte, output last_byte,
                  input ready);
  modport sink (input valid, input opcode, input data_byte, input last_byte,
                output ready);
endinterface

// ===== rtl/mtct_rsp_if.sv =====
// mtct_rsp_if: result channel carrying status and token results
// plain valid/ready handshake; no dependencies
`timescale 1ns / 1ps
interface mtct_rsp_if;
  logic       valid;
  logic       ready;
  logic       is_status;
  logic [2:0] status_code;
  logic [2:0] token_kind;
  logic [7:0] token_char;
  logic [3:0] value_slot;

  modport source (output valid, output is_status, output status_code, output token_kind,
                  output token_char, output value_slot, input ready);
  modport sink (input valid, input is_status, input status_code, input token_kind,
                input token_char, input value_slot, output ready);
endinterface

// ===== rtl/mtct_ram.sv =====
// mtct_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module mtct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/meter_telegram_checker_tokenizer.sv =====
// meter_telegram_checker_tokenizer: telegram framing, crc-16/arc check and field tokenizer
// depends on mtct_pkg, mtct_req_if, mtct_rsp_if and mtct_ram (body store)
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   opcode, data_byte, last_byte
//   rsp_o    out  valid/ready   is_status, status_code, token_kind, token_char, value_slot
//
// a request is taken only when idle; a pull reads body bytes through the single store
// read port, and both the line search and the group search read the store byte by byte
// one result register decouples rsp_o; while it stalls, pushes that deliver no result are
// still taken, one request that does is taken and waits for it, and the input then stalls
// reset clears the framing and scan state; the body store needs no clearing
`timescale 1ns / 1ps
module meter_telegram_checker_tokenizer
  import mtct_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mtct_req_if.sink   req_i,
  mtct_rsp_if.source rsp_o
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_DECODE   = 15'b000000000000010,
    S_FF_START = 15'b000000000000100,
    S_FF_RD    = 15'b000000000001000,
    S_FF_CHK   = 15'b000000000010000,
    S_FF_EVAL  = 15'b000000000100000,
    S_OBIS_RD  = 15'b000000001000000,
    S_OBIS_CHK = 15'b000000010000000,
    S_SG_START = 15'b000000100000000,
    S_SG_CHK0  = 15'b000001000000000,
    S_SG_RD    = 15'b000010000000000,
    S_SG_CHK   = 15'b000100000000000,
    S_VAL_RD   = 15'b001000000000000,
    S_VAL_CHK  = 15'b010000000000000,
    S_EMIT     = 15'b100000000000000
  } state_e;

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  scan_e              step_q, step_d;
  logic [15:0]        crc_q, crc_d;
  logic [15:0]        rcv_q, rcv_d;
  logic [2:0]         dcnt_q, dcnt_d;
  logic [POS_W-1:0]   blen_q, blen_d;
  logic [POS_W-1:0]   rp_q, rp_d;
  logic               bad_q, bad_d;
  logic               ovf_q, ovf_d;
  logic               verified_q, verified_d;
  logic               out_valid_q, out_valid_d;

  logic               op_q, op_d;
  logic [7:0]         byte_q, byte_d;
  logic               last_q, last_d;
  logic [POS_W-1:0]   i_q, i_d;
  logic [CAP_W-1:0]   n_q, n_d;
  logic [POS_W-1:0]   trim_q, trim_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   paren_q, paren_d;
  logic [POS_W-1:0]   line_end_q, line_end_d;
  logic [POS_W-1:0]   next_line_q, next_line_d;
  logic [POS_W-1:0]   close_q, close_d;
  logic [POS_W-1:0]   gp_q, gp_d;
  logic [VL_W-1:0]    vlimit_q, vlimit_d;
  logic [VL_W-1:0]    vcount_q, vcount_d;
  logic [VI_W-1:0]    vidx_q, vidx_d;
  logic               first_bad_q, first_bad_d;
  logic               pf_q, pf_d;
  logic               cf_q, cf_d;
  result_t            res_q, res_d;
  result_t            out_q, out_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [7:0]         ram_rdata;

  // push scratch
  phase_e             ph;
  logic [15:0]        pcrc;
  logic [15:0]        prcv;
  logic [2:0]         pdcnt;
  logic [POS_W-1:0]   pblen;
  logic               pbad;
  logic               povf;
  logic [4:0]         nib;
  logic [2:0]         code;
  logic [POS_W-1:0]   id_span;
  logic [POS_W-1:0]   grp_len;
  logic [POS_W-1:0]   pos_inc;

  mtct_ram #(.WIDTH(8), .DEPTH(BODY_DEPTH)) u_body (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (byte_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.is_status   = out_q.is_status;
  assign rsp_o.status_code = out_q.status_code;
  assign rsp_o.token_kind  = out_q.token_kind;
  assign rsp_o.token_char  = out_q.token_char;
  assign rsp_o.value_slot  = out_q.value_slot;

  assign id_span  = paren_q - pos_q;
  assign grp_len  = i_q - gp_q - POS_W'(1);
  assign pos_inc  = pos_q + POS_W'(1);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    step_d      = step_q;
    crc_d       = crc_q;
    rcv_d       = rcv_q;
    dcnt_d      = dcnt_q;
    blen_d      = blen_q;
    rp_d        = rp_q;
    bad_d       = bad_q;
    ovf_d       = ovf_q;
    verified_d  = verified_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    byte_d      = byte_q;
    last_d      = last_q;
    i_d         = i_q;
    n_d         = n_q;
    trim_d      = trim_q;
    pos_d       = pos_q;
    paren_d     = paren_q;
    line_end_d  = line_end_q;
    next_line_d = next_line_q;
    close_d     = close_q;
    gp_d        = gp_q;
    vlimit_d    = vlimit_q;
    vcount_d    = vcount_q;
    vidx_d      = vidx_q;
    first_bad_d = first_bad_q;
    pf_d        = pf_q;
    cf_d        = cf_q;
    res_d       = res_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = blen_q[AW-1:0];
    ram_re      = 1'b0;
    ram_raddr   = i_q[AW-1:0];
    ph          = phase_q;
    pcrc        = crc_q;
    prcv        = rcv_q;
    pdcnt       = dcnt_q;
    pblen       = blen_q;
    pbad        = bad_q;
    povf        = ovf_q;
    nib         = hex_value(byte_q);
    code        = STS_OK;

    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d    = req_i.opcode;
          byte_d  = req_i.data_byte;
          last_d  = req_i.last_byte;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        if (op_q == OP_PUSH) begin
          if (phase_q == PH_DONE) begin
            ph         = PH_SEEK;
            pcrc       = CRC_INIT;
            prcv       = '0;
            pdcnt      = '0;
            pblen      = '0;
            pbad       = 1'b0;
            povf       = 1'b0;
            rp_d       = '0;
            verified_d = 1'b0;
            step_d     = SC_IDLE;
          end
          case (ph)
            PH_SEEK: begin
              if (byte_q == CH_SLASH) begin
                pcrc = crc_byte(CRC_INIT, byte_q);
                ph   = PH_HEAD;
              end
            end
            PH_HEAD: begin
              pcrc = crc_byte(pcrc, byte_q);
              if (byte_q == CH_BANG) ph = PH_DIGITS;
              else if (byte_q == CH_LF) ph = PH_BODY;
            end
            PH_BODY: begin
              pcrc = crc_byte(pcrc, byte_q);
              if (byte_q == CH_BANG) begin
                ph = PH_DIGITS;
              end else if (pblen < POS_W'(BODY_DEPTH)) begin
                ram_we    = 1'b1;
                ram_waddr = pblen[AW-1:0];
                pblen     = pblen + POS_W'(1);
              end else begin
                povf = 1'b1;
              end
            end
            PH_DIGITS: begin
              pbad  = pbad | nib[4];
              prcv  = {prcv[11:0], nib[3:0]};
              pdcnt = pdcnt + 3'd1;
              if (pdcnt >= 3'(CRC_DIGITS)) ph = PH_TAIL;
            end
            default: begin
            end
          endcase
          state_d = S_IDLE;
          if (last_q) begin
            if (ph == PH_SEEK) code = STS_NO_START;
            else if (ph == PH_HEAD || ph == PH_BODY) code = STS_NO_END;
            else if (ph == PH_DIGITS || pbad) code = STS_TRUNC;
            else if (pcrc != prcv) code = STS_CRC;
            else if (povf) code = STS_OVF;
            else code = STS_OK;
            ph         = PH_DONE;
            step_d     = SC_IDLE;
            rp_d       = '0;
            verified_d = (code == STS_OK);
            res_d      = '{is_status: 1'b1, status_code: code, token_kind: TK_OBIS,
                           token_char: 8'h00, value_slot: 4'h0};
            state_d    = S_EMIT;
          end
          phase_d = ph;
          crc_d   = pcrc;
          rcv_d   = prcv;
          dcnt_d  = pdcnt;
          blen_d  = pblen;
          bad_d   = pbad;
          ovf_d   = povf;
        end else begin
          res_d = '{is_status: 1'b0, status_code: STS_OK, token_kind: TK_NONE,
                    token_char: 8'h00, value_slot: 4'h0};
          if (!verified_q) begin
            state_d = S_EMIT;
          end else begin
            case (step_q)
              SC_IDLE: state_d = S_FF_START;
              SC_OBIS: state_d = S_OBIS_RD;
              SC_VALUE: begin
                if (vcount_q < vlimit_q) begin
                  state_d = S_VAL_RD;
                end else begin
                  res_d.token_kind = TK_VAL_END;
                  res_d.value_slot = 4'(vidx_q);
                  vidx_d           = vidx_q + VI_W'(1);
                  gp_d             = close_q + POS_W'(1);
                  state_d          = S_SG_START;
                end
              end
              default: begin
                step_d           = SC_IDLE;
                rp_d             = next_line_q;
                res_d.token_kind = TK_F_END;
                state_d          = S_EMIT;
              end
            endcase
          end
        end
      end

      S_FF_START: begin
        if (rp_q >= blen_q) begin
          state_d = S_EMIT;
        end else begin
          i_d         = rp_q;
          n_d         = '0;
          trim_d      = rp_q;
          pos_d       = rp_q;
          first_bad_d = 1'b0;
          pf_d        = 1'b0;
          cf_d        = 1'b0;
          state_d     = S_FF_RD;
        end
      end

      S_FF_RD: begin
        if (i_q < blen_q) begin
          ram_re    = 1'b1;
          ram_raddr = i_q[AW-1:0];
          state_d   = S_FF_CHK;
        end else begin
          next_line_d = i_q;
          state_d     = S_FF_EVAL;
        end
      end

      S_FF_CHK: begin
        if (ram_rdata == CH_LF) begin
          next_line_d = i_q + POS_W'(1);
          state_d     = S_FF_EVAL;
        end else if (n_q == CAP_W'(LINE_CAP - 1)) begin
          next_line_d = i_q;
          state_d     = S_FF_EVAL;
        end else begin
          if (n_q == '0) first_bad_d = (ram_rdata == CH_SLASH) || (ram_rdata == CH_BANG);
          if (!is_blank(ram_rdata)) trim_d = i_q + POS_W'(1);
          if (ram_rdata == CH_OPEN && !pf_q) begin
            pf_d    = 1'b1;
            paren_d = i_q;
          end
          if (ram_rdata == CH_CLOSE && pf_q) cf_d = 1'b1;
          i_d     = i_q + POS_W'(1);
          n_d     = n_q + CAP_W'(1);
          state_d = S_FF_RD;
        end
      end

      S_FF_EVAL: begin
        if (trim_q != pos_q && !first_bad_q && pf_q && paren_q != pos_q &&
            id_span < POS_W'(OBIS_MAX) && cf_q) begin
          line_end_d = trim_q;
          vidx_d     = '0;
          step_d     = SC_OBIS;
          state_d    = S_OBIS_RD;
        end else begin
          rp_d    = next_line_q;
          state_d = S_FF_START;
        end
      end

      S_OBIS_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pos_q[AW-1:0];
        state_d   = S_OBIS_CHK;
      end

      S_OBIS_CHK: begin
        res_d.token_kind = TK_OBIS;
        res_d.token_char = ram_rdata;
        pos_d            = pos_inc;
        if (pos_inc >= paren_q) begin
          vidx_d  = '0;
          gp_d    = paren_q;
          state_d = S_SG_START;
        end else begin
          state_d = S_EMIT;
        end
      end

      S_SG_START: begin
        if (vidx_q >= VI_W'(VALUES_MAX) || gp_q >= line_end_q) begin
          step_d  = SC_FEND;
          state_d = S_EMIT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = gp_q[AW-1:0];
          state_d   = S_SG_CHK0;
        end
      end

      S_SG_CHK0: begin
        if (ram_rdata != CH_OPEN) begin
          step_d  = SC_FEND;
          state_d = S_EMIT;
        end else begin
          i_d     = gp_q + POS_W'(1);
          state_d = S_SG_RD;
        end
      end

      S_SG_RD: begin
        if (i_q >= line_end_q) begin
          step_d  = SC_FEND;
          state_d = S_EMIT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = i_q[AW-1:0];
          state_d   = S_SG_CHK;
        end
      end

      S_SG_CHK: begin
        if (ram_rdata == CH_CLOSE) begin
          step_d   = SC_VALUE;
          pos_d    = gp_q + POS_W'(1);
          vlimit_d = (grp_len >= POS_W'(VALUE_MAX)) ? VL_W'(VALUE_MAX - 1)
                                                    : grp_len[VL_W-1:0];
          vcount_d = '0;
          close_d  = i_q;
          state_d  = S_EMIT;
        end else begin
          i_d     = i_q + POS_W'(1);
          state_d = S_SG_RD;
        end
      end

      S_VAL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(pos_q + POS_W'(vcount_q));
        state_d   = S_VAL_CHK;
      end

      S_VAL_CHK: begin
        res_d.token_kind = TK_VALUE;
        res_d.token_char = ram_rdata;
        res_d.value_slot = 4'(vidx_q);
        vcount_d         = vcount_q + VL_W'(1);
        state_d          = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_SEEK;
      step_q      <= SC_IDLE;
      crc_q       <= CRC_INIT;
      rcv_q       <= '0;
      dcnt_q      <= '0;
      blen_q      <= '0;
      rp_q        <= '0;
      bad_q       <= 1'b0;
      ovf_q       <= 1'b0;
      verified_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      crc_q       <= crc_d;
      rcv_q       <= rcv_d;
      dcnt_q      <= dcnt_d;
      blen_q      <= blen_d;
      rp_q        <= rp_d;
      bad_q       <= bad_d;
      ovf_q       <= ovf_d;
      verified_q  <= verified_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    byte_q      <= byte_d;
    last_q      <= last_d;
    i_q         <= i_d;
    n_q         <= n_d;
    trim_q      <= trim_d;
    pos_q       <= pos_d;
    paren_q     <= paren_d;
    line_end_q  <= line_end_d;
    next_line_q <= next_line_d;
    close_q     <= close_d;
    gp_q        <= gp_d;
    vlimit_q    <= vlimit_d;
    vcount_q    <= vcount_d;
    vidx_q      <= vidx_d;
    first_bad_q <= first_bad_d;
    pf_q        <= pf_d;
    cf_q        <= cf_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  // body reads stay inside the bytes stored for this telegram
  a_read_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (POS_W'(ram_raddr) < blen_q))
    else $error("body read beyond stored length");

  a_verified_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verified_q |-> (phase_q == PH_DONE))
    else $error("verified telegram outside done phase");

  a_scan_needs_verified: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != SC_IDLE) |-> verified_q)
    else $error("line scan active without verified telegram");

  a_read_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= blen_q)
    else $error("read position past body length");

  a_no_write_in_pull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_DECODE && op_q == OP_PUSH && !ram_re))
    else $error("body write outside a push");

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for meter_telegram_checker_tokenizer, framing, crc and tokens
// depends on mtct_pkg, mtct_req_if, mtct_rsp_if and the block's rtl
`timescale 1ns / 1ps
module tb;
  import mtct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  mtct_req_if req ();
  mtct_rsp_if rsp ();

  meter_telegram_checker_tokenizer i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  // expected results and run bookkeeping
  result_t expected_q[$];
  int errors = 0;
  int n_requests = 0;
  int n_status = 0;
  int n_tokens = 0;
  int n_telegrams = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int unsigned cycles = 0;
  logic [2:0] last_kind;
  logic [7:0] tg[$];

  // predictor state
  logic [7:0] body_mem[BODY_DEPTH];
  int unsigned body_len, read_pos;
  logic [15:0] calc_crc, rx_crc;
  phase_e phase;
  int unsigned ndigits;
  bit saw_bad_digit, saw_overflow;
  bit verified;
  scan_e step;
  int unsigned line_end, next_line, paren, pos, close_at, vlimit, vcount, vidx;

  function automatic logic [15:0] crc16_arc(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic logic [7:0] body_at(int unsigned i);
    return (i < body_len && i < BODY_DEPTH) ? body_mem[i] : 8'h00;
  endfunction

  function automatic bit blank_ch(logic [7:0] c);
    return c == CH_CR || c == CH_LF || c == CH_SP || c == CH_TAB;
  endfunction

  function automatic void add_token(logic [2:0] k, logic [7:0] c, logic [3:0] s);
    result_t r;
    r = '{is_status: 1'b0, status_code: STS_OK, token_kind: k, token_char: c, value_slot: s};
    expected_q.push_back(r);
    last_kind = k;
  endfunction

  function automatic void clear_scan();
    verified = 0;
    step = SC_IDLE;
    {line_end, next_line, paren, pos, close_at, vlimit, vcount, vidx} = '0;
  endfunction

  function automatic void new_frame();
    calc_crc = CRC_INIT;
    rx_crc = '0;
    ndigits = 0;
    body_len = 0;
    read_pos = 0;
    saw_bad_digit = 0;
    saw_overflow = 0;
    clear_scan();
    phase = PH_SEEK;
  endfunction

  function automatic void open_group(int unsigned p);
    int unsigned len;
    if (vidx < VALUES_MAX && p < line_end && body_at(p) == CH_OPEN) begin
      for (int unsigned q = p + 1; q < line_end; q++) begin
        if (body_at(q) == CH_CLOSE) begin
          len = q - p - 1;
          step = SC_VALUE;
          pos = p + 1;
          vlimit = (len >= VALUE_MAX) ? VALUE_MAX - 1 : len;
          vcount = 0;
          close_at = q;
          return;
        end
      end
    end
    step = SC_FEND;
  endfunction

  function automatic bit next_field();
    int unsigned start, i, n, e, p;
    bit ok;
    while (read_pos < body_len) begin
      start = read_pos;
      i = start;
      n = 0;
      while (i < body_len && body_at(i) != CH_LF && n < LINE_CAP - 1) begin
        i++;
        n++;
      end
      e = i;
      if (i < body_len && body_at(i) == CH_LF) i++;
      while (e > start && blank_ch(body_at(e - 1))) e--;
      ok = e > start && body_at(start) != CH_SLASH && body_at(start) != CH_BANG;
      if (ok) begin
        p = start;
        while (p < e && body_at(p) != CH_OPEN) p++;
        ok = 0;
        if (!(p == e || p == start || p - start >= OBIS_MAX)) begin
          for (int unsigned q = p + 1; q < e; q++) if (body_at(q) == CH_CLOSE) ok = 1;
        end
        if (ok) begin
          line_end = e;
          next_line = i;
          paren = p;
          pos = start;
          vidx = 0;
          step = SC_OBIS;
          return 1;
        end
      end
      read_pos = i;
    end
    return 0;
  endfunction

  function automatic void predict_pull();
    logic [7:0] ch;
    if (!verified || (step == SC_IDLE && !next_field())) begin
      add_token(TK_NONE, 8'h00, 4'd0);
      return;
    end
    case (step)
      SC_OBIS: begin
        ch = body_at(pos);
        pos++;
        if (pos >= paren) begin
          vidx = 0;
          open_group(paren);
        end
        add_token(TK_OBIS, ch, 4'd0);
      end
      SC_VALUE: begin
        if (vcount < vlimit) begin
          ch = body_at(pos + vcount);
          vcount++;
          add_token(TK_VALUE, ch, vidx[3:0]);
        end else begin
          add_token(TK_VAL_END, 8'h00, vidx[3:0]);
          vidx++;
          open_group(close_at + 1);
        end
      end
      default: begin
        step = SC_IDLE;
        read_pos = next_line;
        add_token(TK_F_END, 8'h00, 4'd0);
      end
    endcase
  endfunction

  function automatic void predict(logic op, logic [7:0] b, logic last);
    int nib;
    result_t r;
    if (op == OP_PULL) begin
      predict_pull();
      return;
    end
    if (phase == PH_DONE) new_frame();
    case (phase)
      PH_SEEK: if (b == CH_SLASH) begin
        calc_crc = crc16_arc(CRC_INIT, b);
        phase = PH_HEAD;
      end
      PH_HEAD: begin
        calc_crc = crc16_arc(calc_crc, b);
        if (b == CH_BANG) phase = PH_DIGITS;
        else if (b == CH_LF) phase = PH_BODY;
      end
      PH_BODY: begin
        calc_crc = crc16_arc(calc_crc, b);
        if (b == CH_BANG) phase = PH_DIGITS;
        else if (body_len < BODY_DEPTH) body_mem[body_len++] = b;
        else saw_overflow = 1;
      end
      PH_DIGITS: begin
        nib = hex_nibble(b);
        if (nib < 0) saw_bad_digit = 1;
        rx_crc = {rx_crc[11:0], 4'(nib)};
        ndigits++;
        if (ndigits >= CRC_DIGITS) phase = PH_TAIL;
      end
      default: ;
    endcase
    if (!last) return;
    r = '0;
    r.is_status = 1'b1;
    if (phase == PH_SEEK) r.status_code = STS_NO_START;
    else if (phase == PH_HEAD || phase == PH_BODY) r.status_code = STS_NO_END;
    else if (phase == PH_DIGITS || saw_bad_digit) r.status_code = STS_TRUNC;
    else if (calc_crc != rx_crc) r.status_code = STS_CRC;
    else if (saw_overflow) r.status_code = STS_OVF;
    else r.status_code = STS_OK;
    phase = PH_DONE;
    clear_scan();
    read_pos = 0;
    verified = (r.status_code == STS_OK);
    expected_q.push_back(r);
    last_kind = TK_NONE;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected result, kind", rsp.token_kind, -1);
      end else begin
        e = expected_q.pop_front();
        if (rsp.is_status) n_status++;
        else n_tokens++;
        if (rsp.is_status !== e.is_status) report("is_status", rsp.is_status, e.is_status);
        if (rsp.status_code !== e.status_code)
          report("status_code", rsp.status_code, e.status_code);
        if (rsp.token_kind !== e.token_kind) report("token_kind", rsp.token_kind, e.token_kind);
        if (rsp.token_char !== e.token_char) report("token_char", rsp.token_char, e.token_char);
        if (rsp.value_slot !== e.value_slot) report("value_slot", rsp.value_slot, e.value_slot);
      end
    end
  end

  // receiver stalls and long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      rsp.ready = 1'b0;
    end else begin
      rsp.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_req(logic op, logic [7:0] b, logic last);
    while ($urandom_range(99) < gap_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.opcode = op;
    req.data_byte = b;
    req.last_byte = last;
    do @(posedge clk); while (!req.ready);
    predict(op, b, last);
    n_requests++;
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  task automatic push_telegram();
    for (int i = 0; i < tg.size(); i++) send_req(OP_PUSH, tg[i], i == tg.size() - 1);
    n_telegrams++;
  endtask

  task automatic pull_all(int extra);
    do send_req(OP_PULL, 8'($urandom), 1'($urandom)); while (last_kind != TK_NONE);
    repeat (extra) send_req(OP_PULL, 8'($urandom), 1'($urandom));
  endtask

  function automatic logic [7:0] hex_char(int n, bit lower);
    if (n < 10) return 8'("0" + n);
    return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7E));
    end while (c == CH_BANG || c == CH_CLOSE || c == CH_LF);
    return c;
  endfunction

  function automatic void add_str(string s);
    foreach (s[i]) tg.push_back(s[i]);
  endfunction

  function automatic void add_line();
    string obis_set;
    int olen, ngroups, vlen;
    logic [7:0] c;
    obis_set = "0123456789.:-*";
    case ($urandom_range(9))
      0: add_str("\r\n");
      1: begin
        repeat ($urandom_range(30)) begin
          do c = 8'($urandom); while (c == CH_BANG);
          tg.push_back(c);
        end
        tg.push_back(CH_LF);
      end
      2: add_str("/x(1)\n");
      default: begin
        olen = ($urandom_range(7) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 10);
        repeat (olen) tg.push_back(obis_set[$urandom_range(obis_set.len() - 1)]);
        ngroups = ($urandom_range(7) == 0) ? $urandom_range(0, 14) : $urandom_range(1, 3);
        for (int g = 0; g < ngroups; g++) begin
          vlen = ($urandom_range(9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
          tg.push_back(CH_OPEN);
          repeat (vlen) tg.push_back(value_char());
          if (!(g == ngroups - 1 && $urandom_range(9) == 0)) tg.push_back(CH_CLOSE);
        end
        if ($urandom_range(3) == 0) tg.push_back($urandom_range(1) ? CH_SP : CH_TAB);
        if ($urandom_range(1)) tg.push_back(CH_CR);
        tg.push_back(CH_LF);
      end
    endcase
  endfunction

  // mode 0 good crc, 1 wrong crc, 2 bad digit, 3 truncated, 4 no end
  function automatic void build_telegram(int nlines, int mode, int body_bytes);
    logic [15:0] crc;
    int first;
    logic [7:0] c;
    bit lower;
    tg.delete();
    repeat ($urandom_range(3)) begin
      do c = 8'($urandom); while (c == CH_SLASH);
      tg.push_back(c);
    end
    first = tg.size();
    add_str("/MTR5");
    repeat ($urandom_range(4)) tg.push_back(8'($urandom_range("A", "Z")));
    add_str("\r\n");
    repeat (nlines) add_line();
    while (tg.size() - first < body_bytes) add_str("1-0:1.8.1(0042*kWh)\r\n");
    if (mode == 4) return;
    tg.push_back(CH_BANG);
    crc = CRC_INIT;
    for (int i = first; i < tg.size(); i++) crc = crc16_arc(crc, tg[i]);
    if (mode == 1) crc ^= 16'(1 << $urandom_range(15));
    lower = $urandom_range(1);
    for (int d = 3; d >= 0; d--) begin
      if (mode == 3 && d == 1) return;
      tg.push_back(hex_char(crc[d*4 +: 4], lower));
    end
    if (mode == 2) tg[tg.size() - 1 - $urandom_range(3)] = "g";
    repeat ($urandom_range(2)) tg.push_back(8'($urandom));
  endfunction

  task automatic test_status_codes();
    send_req(OP_PUSH, 8'h41, 1'b1);
    tg.delete();
    add_str("/A\n1(2)\n");
    push_telegram();
    build_telegram(1, 3, 0);
    push_telegram();
    build_telegram(1, 2, 0);
    push_telegram();
    build_telegram(1, 1, 0);
    push_telegram();
    pull_all(1);
  endtask

  task automatic test_tokens();
    pull_all(0);
    tg.delete();
    add_str("/H\n1-0:1(0");
    tg.push_back(8'h00);
    add_str("\xff)(ab)()\n!");
    begin
      logic [15:0] crc;
      crc = CRC_INIT;
      for (int i = 0; i < tg.size(); i++) crc = crc16_arc(crc, tg[i]);
      for (int d = 3; d >= 0; d--) tg.push_back(hex_char(crc[d*4 +: 4], 0));
    end
    push_telegram();
    pull_all(2);
  endtask

  task automatic test_random(int budget);
    int stop_at;
    int mode;
    stop_at = n_requests + budget;
    while (n_requests < stop_at) begin
      mode = ($urandom_range(9) < 6) ? 0 : $urandom_range(1, 4);
      build_telegram($urandom_range(1, 4), mode, 0);
      push_telegram();
      pull_all($urandom_range(1));
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, 6)) send_req(1'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_backpressure();
    build_telegram(3, 0, 0);
    push_telegram();
    @(negedge clk);
    hold_cycles = 400;
    repeat (30) send_req(OP_PULL, 8'h00, 1'b0);
    pull_all(0);
  endtask

  initial begin
    req.valid = 1'b0;
    req.opcode = OP_PUSH;
    req.data_byte = '0;
    req.last_byte = 1'b0;
    rsp.ready = 1'b0;
    new_frame();
    last_kind = TK_NONE;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_status_codes();
    test_tokens();
    gap_pct = 0;  stall_pct = 0;  test_random(330);
    gap_pct = 75; stall_pct = 0;  test_random(330);
    gap_pct = 0;  stall_pct = 75; test_random(330);
    gap_pct = 33; stall_pct = 33; test_random(330);
    test_backpressure();
    req.valid = 1'b0;
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("covered %0d requests over %0d telegrams: %0d statuses, %0d tokens checked",
             n_requests, n_telegrams, n_status, n_tokens);
    $display("idle mixes and a long receiver hold-off exercised, %0d errors", errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
